FILE: rtl/core/mrfc_pkg.sv
// Shared constants, item types and the CRC-16 byte update of the request frame checker.
`default_nettype none

package mrfc_pkg;

   // CRC-16, reflected form
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // accepted function codes
   localparam logic [7:0] FUNC_LOW  = 8'h03;
   localparam logic [7:0] FUNC_HIGH = 8'h06;

   // frame length and byte counter ceiling
   localparam logic [3:0] FRAME_LEN = 4'd8;
   localparam logic [3:0] COUNT_SAT = 4'd9;

   // verdict codes, first failing check wins
   typedef enum logic [2:0] {
      VERDICT_OK           = 3'd0,
      VERDICT_BAD_LENGTH   = 3'd1,
      VERDICT_BAD_FUNCTION = 3'd2,
      VERDICT_ZERO_ADDRESS = 3'd3,
      VERDICT_CRC_MISMATCH = 3'd4
   } verdict_type;

   // one received byte as held in the input register
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } rx_item_type;

   // one frame verdict with the captured fields
   typedef struct packed {
      verdict_type verdict;
      logic [7:0]  station_address;
      logic [7:0]  function_code;
      logic [15:0] register_address;
      logic [15:0] data_word;
   } result_type;

   // fold one byte into the CRC, low bit first
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mrfc_req_if.sv
// Request byte channel: valid, ready and one received byte with its end-of-frame flag.
`default_nettype none

interface mrfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mrfc_rsp_if.sv
// Verdict channel: valid, ready and one frame verdict with its captured fields.
`default_nettype none

interface mrfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  verdict;
   logic [7:0]  station_address;
   logic [7:0]  function_code;
   logic [15:0] register_address;
   logic [15:0] data_word;

   modport source (output valid, output verdict, output station_address,
                   output function_code, output register_address, output data_word,
                   input ready);
   modport sink (input valid, input verdict, input station_address,
                 input function_code, input register_address, input data_word,
                 output ready);
endinterface

`default_nettype wire

FILE: rtl/core/modbus_request_frame_checker_unit.sv
// Modbus RTU request frame checker: CRC-16 and field checks over a byte stream, one verdict per frame.
//
// req_chan carries one received byte per item, with frame_end set on the last byte of a frame.
// rsp_chan carries one item per frame: the verdict (ok, bad length, bad function, zero
// register address, CRC mismatch, first failing check wins) and the captured station,
// function code, register address and data word. Bytes without frame_end give no item.
// Throughput: one byte per clock while no end byte waits in the input register for room in the
// result register. The byte-wide CRC update, the field capture and the verdict sit between the
// input register and the result register. A byte taken from the input register is folded into
// the frame state; for an end byte the verdict is written into the result register as it is taken.
// Stall: the result register holds the verdict while rsp_chan.ready is low. Ordinary
// bytes keep flowing; a second end byte waits in the input register, and req_chan.ready
// drops only once that register is full and cannot drain.
// Reset (synchronous, active high) empties both registers and restarts the frame state:
// byte count 0, CRC 0xFFFF, captured fields 0. The state also restarts after every verdict.
`default_nettype none

module modbus_request_frame_checker_unit (
   input  wire        clock,
   input  wire        reset,
   mrfc_req_if.sink   req_chan,
   mrfc_rsp_if.source rsp_chan
);

   logic                  item_valid;
   mrfc_pkg::rx_item_type item;
   logic                  take;
   logic                  out_free;
   logic                  res_valid;
   mrfc_pkg::result_type  res;

   mrfc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   mrfc_frame_core u_frame_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .take       (take),
      .res_valid  (res_valid),
      .res        (res)
   );

   mrfc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

FILE: rtl/core/mrfc_in_stage.sv
// Input register: holds one accepted byte until the frame logic takes it.
`default_nettype none

module mrfc_in_stage (
   input  wire                   clock,
   input  wire                   reset,
   mrfc_req_if.sink              req_chan,
   input  wire                   take,
   output logic                  item_valid,
   output mrfc_pkg::rx_item_type item
);

   logic                  vld_ff, vld_in;
   mrfc_pkg::rx_item_type item_ff;
   logic                  load;

   // accept when empty or when the held item leaves this cycle
   assign req_chan.ready = !vld_ff || take;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      if (load) begin
         vld_in = 1'b1;
      end else if (take) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // hold the byte payload
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.rx_byte   <= req_chan.rx_byte;
         item_ff.frame_end <= req_chan.frame_end;
      end
   end

   assign item_valid = vld_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

FILE: rtl/core/mrfc_frame_core.sv
// Frame state: byte counter, CRC accumulator, field capture and the end-of-frame verdict.
`default_nettype none

module mrfc_frame_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   item_valid,
   input  mrfc_pkg::rx_item_type item,
   input  wire                   out_free,
   output logic                  take,
   output logic                  res_valid,
   output mrfc_pkg::result_type  res
);

   // byte positions within the frame
   localparam logic [3:0] POS_STATION  = 4'd0;
   localparam logic [3:0] POS_FUNCTION = 4'd1;
   localparam logic [3:0] POS_ADDR_HI  = 4'd2;
   localparam logic [3:0] POS_ADDR_LO  = 4'd3;
   localparam logic [3:0] POS_DATA_HI  = 4'd4;
   localparam logic [3:0] POS_DATA_LO  = 4'd5;
   localparam logic [3:0] POS_CRC_LO   = 4'd6;
   localparam logic [3:0] POS_CRC_HI   = 4'd7;

   logic [3:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  station_ff, station_in;
   logic [7:0]  function_ff, function_in;
   logic [15:0] address_ff, address_in;
   logic [15:0] value_ff, value_in;
   logic [15:0] crc_rx_ff, crc_rx_in;

   // an end byte waits until the result register has room
   assign take      = item_valid && (!item.frame_end || out_free);
   assign res_valid = take && item.frame_end;

   // fold the byte into the frame state
   always_comb begin
      station_in  = station_ff;
      function_in = function_ff;
      address_in  = address_ff;
      value_in    = value_ff;
      crc_rx_in   = crc_rx_ff;
      crc_in      = (count_ff < POS_CRC_LO) ? mrfc_pkg::crc_update(crc_ff, item.rx_byte)
                                            : crc_ff;
      count_in    = (count_ff < mrfc_pkg::COUNT_SAT) ? count_ff + 4'd1 : count_ff;
      case (count_ff)
         POS_STATION:  station_in  = item.rx_byte;
         POS_FUNCTION: function_in = item.rx_byte;
         POS_ADDR_HI:  address_in  = {item.rx_byte, address_ff[7:0]};
         POS_ADDR_LO:  address_in  = {address_ff[15:8], item.rx_byte};
         POS_DATA_HI:  value_in    = {item.rx_byte, value_ff[7:0]};
         POS_DATA_LO:  value_in    = {value_ff[15:8], item.rx_byte};
         POS_CRC_LO:   crc_rx_in   = {crc_rx_ff[15:8], item.rx_byte};
         POS_CRC_HI:   crc_rx_in   = {item.rx_byte, crc_rx_ff[7:0]};
         default:      ;
      endcase
   end

   // judge the frame on its last byte
   always_comb begin
      if (count_in != mrfc_pkg::FRAME_LEN) begin
         res.verdict = mrfc_pkg::VERDICT_BAD_LENGTH;
      end else if (function_in < mrfc_pkg::FUNC_LOW || function_in > mrfc_pkg::FUNC_HIGH) begin
         res.verdict = mrfc_pkg::VERDICT_BAD_FUNCTION;
      end else if (address_in == 16'h0000) begin
         res.verdict = mrfc_pkg::VERDICT_ZERO_ADDRESS;
      end else if (crc_in != crc_rx_in) begin
         res.verdict = mrfc_pkg::VERDICT_CRC_MISMATCH;
      end else begin
         res.verdict = mrfc_pkg::VERDICT_OK;
      end
      res.station_address  = station_in;
      res.function_code    = function_in;
      res.register_address = address_in;
      res.data_word        = value_in;
   end

   // advance on each byte taken, clear after the last one
   always_ff @(posedge clock) begin
      if (reset || res_valid) begin
         count_ff    <= 4'd0;
         crc_ff      <= mrfc_pkg::CRC_INIT;
         station_ff  <= 8'h00;
         function_ff <= 8'h00;
         address_ff  <= 16'h0000;
         value_ff    <= 16'h0000;
         crc_rx_ff   <= 16'h0000;
      end else if (take) begin
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         station_ff  <= station_in;
         function_ff <= function_in;
         address_ff  <= address_in;
         value_ff    <= value_in;
         crc_rx_ff   <= crc_rx_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/mrfc_out_stage.sv
// Result register: holds one verdict item until the receiver takes it.
`default_nettype none

module mrfc_out_stage (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  res_valid,
   input  mrfc_pkg::result_type res,
   output logic                 out_free,
   mrfc_rsp_if.source           rsp_chan
);

   logic                 vld_ff, vld_in;
   mrfc_pkg::result_type res_ff;

   // room when empty or when the held item is taken this cycle
   assign out_free = !vld_ff || rsp_chan.ready;

   always_comb begin
      if (res_valid) begin
         vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // hold the result payload
   always_ff @(posedge clock) begin
      if (res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_chan.valid            = vld_ff;
   assign rsp_chan.verdict          = res_ff.verdict;
   assign rsp_chan.station_address  = res_ff.station_address;
   assign rsp_chan.function_code    = res_ff.function_code;
   assign rsp_chan.register_address = res_ff.register_address;
   assign rsp_chan.data_word        = res_ff.data_word;

endmodule

`default_nettype wire
